FILE: design/yafr_pkg.sv
// Package for the 4:2:0 alpha fade recode block.
// Holds the stage-advance struct, the BT.601 constants and the shift and clamp helpers.
// No dependencies.
package yafr_pkg;

   localparam int unsigned PixWidth = 8;
   localparam int unsigned SumWidth = 16;

   localparam logic [SumWidth-1:0] KR_OFFSET    = 16'd24224;
   localparam logic [SumWidth-1:0] KG_OFFSET    = 16'd2016;
   localparam logic [SumWidth-1:0] KB_OFFSET    = 16'd5152;
   localparam logic [SumWidth-1:0] KY_MUL       = 16'd42;
   localparam logic [SumWidth-1:0] KRV_MUL      = 16'd153;
   localparam logic [SumWidth-1:0] KGV_MUL      = 16'd47;
   localparam logic [SumWidth-1:0] KGU_MUL      = 16'd100;
   localparam logic [SumWidth-1:0] KY_OFF_A     = 16'd8192;
   localparam logic [SumWidth-1:0] KY_OFF_B     = 16'd16384;
   localparam logic [SumWidth-1:0] KY_BIAS      = 16'd112;
   localparam logic [SumWidth-1:0] KC_BIAS      = 16'd128;
   localparam logic [SumWidth-1:0] KB_BIAS      = 16'd256;

   localparam logic [PixWidth-1:0] ALPHA_RESET  = 8'd1;

   // register word indexes on the configuration port
   localparam logic REG_ALPHA = 1'b0;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } adv_type;

   // floor(x / 256) of a 16-bit value, sign extended back to 16 bits
   function automatic logic [SumWidth-1:0] sra8(input logic [SumWidth-1:0] x);
      sra8 = {{8{x[15]}}, x[15:8]};
   endfunction

   // saturate a signed 16-bit value to 0..255
   function automatic logic [PixWidth-1:0] clamp_u8(input logic [SumWidth-1:0] x);
      if (x[15]) begin
         clamp_u8 = 8'd0;
      end else if (x[14:8] != 7'd0) begin
         clamp_u8 = 8'd255;
      end else begin
         clamp_u8 = x[7:0];
      end
   endfunction

endpackage

FILE: design/yafr_lane.sv
// One pixel lane of the alpha fade recode: YUV to RGB, fade, RGB back to luma.
// Five register stages, each loaded on its bit of the advance struct.
// Depends on yafr_pkg.
module yafr_lane (
   input  logic                         clock,
   input  yafr_pkg::adv_type            adv,
   input  logic [yafr_pkg::PixWidth-1:0] alpha,
   input  logic [yafr_pkg::PixWidth-1:0] luma,
   input  logic [yafr_pkg::PixWidth-1:0] cb,
   input  logic [yafr_pkg::PixWidth-1:0] cr,
   output logic [yafr_pkg::PixWidth-1:0] fade_r,
   output logic [yafr_pkg::PixWidth-1:0] fade_g,
   output logic [yafr_pkg::PixWidth-1:0] fade_b,
   output logic [yafr_pkg::PixWidth-1:0] luma_out
);

   logic [yafr_pkg::SumWidth-1:0] y16, u16, v16;
   logic [yafr_pkg::SumWidth-1:0] rsum_in, gsum_in, bsum_in;
   logic [yafr_pkg::SumWidth-1:0] rsum_ff, gsum_ff, bsum_ff;
   logic [yafr_pkg::PixWidth-1:0] y1_ff, u1_ff, v1_ff;
   logic [yafr_pkg::SumWidth-1:0] y1w, u1w, v1w;
   logic [yafr_pkg::PixWidth-1:0] r0_in, g0_in, b0_in;
   logic [yafr_pkg::PixWidth-1:0] r0_ff, g0_ff, b0_ff;
   logic [yafr_pkg::SumWidth-1:0] rprod, gprod, bprod;
   logic [yafr_pkg::PixWidth-1:0] r_ff, g_ff, b_ff;
   logic [yafr_pkg::SumWidth-1:0] r16, g16, b16;
   logic [yafr_pkg::SumWidth-1:0] ysum_in, ysum_ff;
   logic [yafr_pkg::PixWidth-1:0] luma_in, luma_ff;

   assign y16 = {8'd0, luma};
   assign u16 = {8'd0, cb};
   assign v16 = {8'd0, cr};

   always_comb begin
      rsum_in = yafr_pkg::KY_MUL * y16 + yafr_pkg::KRV_MUL * v16 - yafr_pkg::KR_OFFSET;
      gsum_in = yafr_pkg::KY_MUL * y16 - yafr_pkg::KGU_MUL * u16 + yafr_pkg::KG_OFFSET
                + yafr_pkg::KGV_MUL * v16;
      bsum_in = yafr_pkg::KY_MUL * y16 + (u16 << 2) - yafr_pkg::KB_OFFSET;
   end

   assign y1w = {8'd0, y1_ff};
   assign u1w = {8'd0, u1_ff};
   assign v1w = {8'd0, v1_ff};

   always_comb begin
      r0_in = yafr_pkg::clamp_u8(yafr_pkg::sra8(rsum_ff) + y1w - yafr_pkg::KC_BIAS + v1w);
      g0_in = yafr_pkg::clamp_u8(yafr_pkg::sra8(gsum_ff) + y1w + yafr_pkg::KC_BIAS - v1w);
      b0_in = yafr_pkg::clamp_u8(yafr_pkg::sra8(bsum_ff) + y1w - yafr_pkg::KB_BIAS
                                 + (u1w << 1));
   end

   assign rprod = {8'd0, alpha} * {8'd0, r0_ff};
   assign gprod = {8'd0, alpha} * {8'd0, g0_ff};
   assign bprod = {8'd0, alpha} * {8'd0, b0_ff};

   assign r16 = {8'd0, r_ff};
   assign g16 = {8'd0, g_ff};
   assign b16 = {8'd0, b_ff};

   always_comb begin
      ysum_in = 16'd66 * r16 - yafr_pkg::KY_OFF_A + 16'd129 * g16 - yafr_pkg::KY_OFF_B
                + 16'd25 * b16;
      luma_in = yafr_pkg::clamp_u8(yafr_pkg::sra8(ysum_ff) + yafr_pkg::KY_BIAS);
   end

   always_ff @(posedge clock) begin
      if (adv.s1) begin
         rsum_ff <= rsum_in;
         gsum_ff <= gsum_in;
         bsum_ff <= bsum_in;
         y1_ff   <= luma;
         u1_ff   <= cb;
         v1_ff   <= cr;
      end
      if (adv.s2) begin
         r0_ff <= r0_in;
         g0_ff <= g0_in;
         b0_ff <= b0_in;
      end
      if (adv.s3) begin
         r_ff <= rprod[15:8];
         g_ff <= gprod[15:8];
         b_ff <= bprod[15:8];
      end
      if (adv.s4) begin
         ysum_ff <= ysum_in;
      end
      if (adv.s5) begin
         luma_ff <= luma_in;
      end
   end

   assign fade_r   = r_ff;
   assign fade_g   = g_ff;
   assign fade_b   = b_ff;
   assign luma_out = luma_ff;

endmodule

FILE: design/yuv420_alpha_fade_recode.sv
// Top level of the 4:2:0 alpha fade recode: handshake, alpha register, four lanes,
// chroma recode of the top-left pixel.
// Depends on yafr_pkg and yafr_lane.
//
// One beat on req_ carries a 2x2 block: four luma samples and the shared U and V.
// One beat on rsp_ returns the four faded luma values and new U and V, the chroma
// taken from the faded top-left pixel only.
// The datapath is a five-stage pipeline: a block accepted into the first stage
// passes the stage registers in order to rsp_valid. Unless req_stall is high, one
// block enters every cycle; throughput is one beat per cycle, set by the stage
// registers, each holding one constant multiply-add, clamp, or 8x8 fade multiply.
// When rsp_stall is high, the output stage holds its beat; earlier stages keep
// filling empty slots, and req_stall rises only once every stage holds a beat
// and the output stage is stalled.
// The alpha register lies at byte address 0 of the csr_ port; writes affect blocks
// processed later; the user must write only while the pipe is empty (not enforced).
// Reset (synchronous, active high) empties the pipeline and sets alpha to 1.
module yuv420_alpha_fade_recode (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_luma_top_left,
   input  logic [7:0]  req_luma_top_right,
   input  logic [7:0]  req_luma_bottom_left,
   input  logic [7:0]  req_luma_bottom_right,
   input  logic [7:0]  req_chroma_blue_in,
   input  logic [7:0]  req_chroma_red_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_luma_out_top_left,
   output logic [7:0]  rsp_luma_out_top_right,
   output logic [7:0]  rsp_luma_out_bottom_left,
   output logic [7:0]  rsp_luma_out_bottom_right,
   output logic [7:0]  rsp_chroma_blue_out,
   output logic [7:0]  rsp_chroma_red_out,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int Stages = 5;

   logic [Stages-1:0]             valid_ff, valid_in, ready;
   yafr_pkg::adv_type             adv;
   logic [yafr_pkg::PixWidth-1:0] alpha_ff, alpha_in;
   logic                          csr_write;
   logic [yafr_pkg::PixWidth-1:0] fade_r, fade_g, fade_b;
   logic [yafr_pkg::SumWidth-1:0] r16, g16, b16;
   logic [yafr_pkg::SumWidth-1:0] cbsum_in, crsum_in, cbsum_ff, crsum_ff;
   logic [yafr_pkg::PixWidth-1:0] cb_in, cr_in, cb_ff, cr_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      alpha_in = alpha_ff;
      if (csr_write && (csr_paddr[2] == yafr_pkg::REG_ALPHA)) begin
         alpha_in = csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == yafr_pkg::REG_ALPHA) begin
         csr_prdata = {24'd0, alpha_ff};
      end
   end

   // stage advance: a stage loads when it is empty or the next one moves
   always_comb begin
      ready[Stages-1] = !valid_ff[Stages-1] || !rsp_stall;
      for (int k = Stages - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in = valid_ff;
      if (ready[0]) begin
         valid_in[0] = req_valid;
      end
      for (int k = 1; k < Stages; k++) begin
         if (ready[k]) begin
            valid_in[k] = valid_ff[k-1];
         end
      end
   end

   assign adv.s1 = ready[0];
   assign adv.s2 = ready[1];
   assign adv.s3 = ready[2];
   assign adv.s4 = ready[3];
   assign adv.s5 = ready[4];

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[Stages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         alpha_ff <= yafr_pkg::ALPHA_RESET;
      end else begin
         valid_ff <= valid_in;
         alpha_ff <= alpha_in;
      end
   end

   // pixel lanes
   yafr_lane u_lane_tl (
      .clock    (clock),
      .adv      (adv),
      .alpha    (alpha_ff),
      .luma     (req_luma_top_left),
      .cb       (req_chroma_blue_in),
      .cr       (req_chroma_red_in),
      .fade_r   (fade_r),
      .fade_g   (fade_g),
      .fade_b   (fade_b),
      .luma_out (rsp_luma_out_top_left)
   );

   yafr_lane u_lane_tr (
      .clock    (clock),
      .adv      (adv),
      .alpha    (alpha_ff),
      .luma     (req_luma_top_right),
      .cb       (req_chroma_blue_in),
      .cr       (req_chroma_red_in),
      .fade_r   (),
      .fade_g   (),
      .fade_b   (),
      .luma_out (rsp_luma_out_top_right)
   );

   yafr_lane u_lane_bl (
      .clock    (clock),
      .adv      (adv),
      .alpha    (alpha_ff),
      .luma     (req_luma_bottom_left),
      .cb       (req_chroma_blue_in),
      .cr       (req_chroma_red_in),
      .fade_r   (),
      .fade_g   (),
      .fade_b   (),
      .luma_out (rsp_luma_out_bottom_left)
   );

   yafr_lane u_lane_br (
      .clock    (clock),
      .adv      (adv),
      .alpha    (alpha_ff),
      .luma     (req_luma_bottom_right),
      .cb       (req_chroma_blue_in),
      .cr       (req_chroma_red_in),
      .fade_r   (),
      .fade_g   (),
      .fade_b   (),
      .luma_out (rsp_luma_out_bottom_right)
   );

   // chroma from the faded top-left pixel
   assign r16 = {8'd0, fade_r};
   assign g16 = {8'd0, fade_g};
   assign b16 = {8'd0, fade_b};

   always_comb begin
      cbsum_in = 16'd112 * b16 - 16'd38 * r16 + yafr_pkg::KC_BIAS - 16'd74 * g16;
      crsum_in = 16'd112 * r16 - 16'd94 * g16 + yafr_pkg::KC_BIAS - 16'd18 * b16;
      cb_in    = yafr_pkg::clamp_u8(yafr_pkg::sra8(cbsum_ff) + yafr_pkg::KC_BIAS);
      cr_in    = yafr_pkg::clamp_u8(yafr_pkg::sra8(crsum_ff) + yafr_pkg::KC_BIAS);
   end

   always_ff @(posedge clock) begin
      if (adv.s4) begin
         cbsum_ff <= cbsum_in;
         crsum_ff <= crsum_in;
      end
      if (adv.s5) begin
         cb_ff <= cb_in;
         cr_ff <= cr_in;
      end
   end

   assign rsp_chroma_blue_out = cb_ff;
   assign rsp_chroma_red_out  = cr_ff;

endmodule
